/* src/pps_pkg.sv */
`default_nettype none

package pps_pkg;

  localparam int HEAP_DEPTH_DEF = 64;

  localparam int CMD_W    = 1;
  localparam int ID_W     = 8;
  localparam int PRIO_W   = 8;
  localparam int BURST_W  = 16;
  localparam int STATUS_W = 3;
  localparam int TIME_W   = 32;

  localparam logic [CMD_W-1:0] CMD_ARRIVE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ACCEPT   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJ_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REJ_ZERO = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RAN      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd5;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] remaining;
    logic [BURST_W-1:0] original;
    logic [TIME_W-1:0]  arrival;
    logic [TIME_W-1:0]  resp;
    logic               started;
  } heap_entry_t;

  typedef struct packed {
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] turnaround;
  } fin_stats_t;

endpackage

`default_nettype wire

/* src/pps_finish.sv */
`default_nettype none

module pps_finish (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [pps_pkg::TIME_W-1:0]  now,
  input  logic [pps_pkg::TIME_W-1:0]  arrival,
  input  logic [pps_pkg::BURST_W-1:0] original,
  output pps_pkg::fin_stats_t         stats,
  output logic                        done
);
  import pps_pkg::*;

  logic [TIME_W:0]    plus_r;
  logic [TIME_W:0]    minus_r;
  logic [BURST_W-1:0] orig1_r;
  logic [BURST_W-1:0] orig2_r;
  logic [TIME_W-1:0]  wait_r;
  logic [TIME_W-1:0]  turn_r;
  logic [1:0]         v_r;
  logic               done_r;

  logic [TIME_W:0]    diff;
  logic [TIME_W-1:0]  wait_nxt;
  logic [TIME_W:0]    sum;
  logic [TIME_W-1:0]  turn_nxt;

  always_comb begin
    diff = plus_r - minus_r;
    if (plus_r > minus_r) begin
      wait_nxt = diff[TIME_W] ? {TIME_W{1'b1}} : diff[TIME_W-1:0];
    end else begin
      wait_nxt = '0;
    end
    sum      = {1'b0, wait_r} + (TIME_W + 1)'(orig2_r);
    turn_nxt = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      plus_r  <= {1'b0, now} + (TIME_W + 1)'(1);
      minus_r <= {1'b0, arrival} + (TIME_W + 1)'(original);
      orig1_r <= original;
    end
    wait_r  <= wait_nxt;
    orig2_r <= orig1_r;
    turn_r  <= turn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      done_r <= 1'b0;
    end else begin
      v_r <= {v_r[0], load};
      if (load) begin
        done_r <= 1'b0;
      end else if (v_r[1]) begin
        done_r <= 1'b1;
      end
    end
  end

  assign stats.waiting    = wait_r;
  assign stats.turnaround = turn_r;
  assign done             = done_r;

endmodule

`default_nettype wire

/* src/preemptive_priority_scheduler.sv */
// Preemptive priority scheduler. Each request is either a job arrival or a
// time tick and yields exactly one result. Jobs wait in a binary min-heap of
// HEAP_DEPTH entries held in a synchronous RAM with one read port and one
// write port; lower priority numbers run first and ties keep heap order.
// One request is in flight at a time. An accepted arrival climbs the heap
// from the last slot; a tick takes the root, sifts the last entry down from
// the root and reinserts the job that ran if burst remains. Rejects and idle
// ticks touch no heap entry. A new request is taken while the previous
// result still waits in the output register.
`default_nettype none

module preemptive_priority_scheduler #(
  parameter int HEAP_DEPTH = pps_pkg::HEAP_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pps_pkg::CMD_W-1:0]    in_cmd,
  input  logic [pps_pkg::ID_W-1:0]     in_job_id,
  input  logic [pps_pkg::PRIO_W-1:0]   in_job_priority,
  input  logic [pps_pkg::BURST_W-1:0]  in_job_burst,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pps_pkg::STATUS_W-1:0] out_status,
  output logic [pps_pkg::ID_W-1:0]     out_run_id,
  output logic [pps_pkg::TIME_W-1:0]   out_tick_time,
  output logic [pps_pkg::BURST_W-1:0]  out_remaining_burst,
  output logic [pps_pkg::TIME_W-1:0]   out_response_time,
  output logic [pps_pkg::TIME_W-1:0]   out_waiting_time,
  output logic [pps_pkg::TIME_W-1:0]   out_turnaround_time
);
  import pps_pkg::*;

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int XW = AW + 2;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_ROOT   = 4'd2;
  localparam logic [3:0] S_LAST   = 4'd3;
  localparam logic [3:0] S_DN_L   = 4'd4;
  localparam logic [3:0] S_DN_R   = 4'd5;
  localparam logic [3:0] S_DN_CMP = 4'd6;
  localparam logic [3:0] S_PUSH   = 4'd7;
  localparam logic [3:0] S_UP     = 4'd8;
  localparam logic [3:0] S_UP_CMP = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  // heap RAM
  heap_entry_t mem_r [HEAP_DEPTH];
  heap_entry_t rd_r;
  logic        we;
  logic [AW-1:0] wa;
  logic [AW-1:0] ra;
  heap_entry_t wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    rd_r <= mem_r[ra];
  end

  logic [3:0]          state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [PRIO_W-1:0]   prio_r, prio_nxt;
  logic [BURST_W-1:0]  burst_r, burst_nxt;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  heap_entry_t         x_r, x_nxt;
  heap_entry_t         run_r, run_nxt;
  heap_entry_t         c_r, c_nxt;
  logic                hasr_r, hasr_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic [TIME_W-1:0]   res_time_r, res_time_nxt;
  logic [BURST_W-1:0]  res_rem_r, res_rem_nxt;
  logic [TIME_W-1:0]   res_resp_r, res_resp_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [TIME_W-1:0]   out_time_r;
  logic [BURST_W-1:0]  out_rem_r;
  logic [TIME_W-1:0]   out_resp_r;
  logic [TIME_W-1:0]   out_wait_r;
  logic [TIME_W-1:0]   out_turn_r;
  logic                out_load;

  logic                fin_load;
  fin_stats_t          fin_stats;
  logic                fin_done;

  logic [XW-1:0]       l_x;
  logic [XW-1:0]       r_x;
  logic [XW-1:0]       cnt_x;
  logic [AW-1:0]       par;
  logic                pick_l;
  logic                pick_r;
  logic [PRIO_W-1:0]   best_prio;
  logic [TIME_W-1:0]   root_resp;
  logic [BURST_W-1:0]  root_rem;

  assign l_x       = {1'b0, pos_r, 1'b1};
  assign r_x       = l_x + XW'(1);
  assign cnt_x     = XW'(count_r);
  assign par       = AW'((pos_r - AW'(1)) >> 1);
  assign pick_l    = c_r.prio < x_r.prio;
  assign best_prio = pick_l ? c_r.prio : x_r.prio;
  assign pick_r    = hasr_r && (rd_r.prio < best_prio);
  assign root_resp = rd_r.started ? rd_r.resp : (res_time_r - rd_r.arrival);
  assign root_rem  = (rd_r.remaining != '0) ? (rd_r.remaining - BURST_W'(1)) : '0;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    prio_nxt       = prio_r;
    burst_nxt      = burst_r;
    time_nxt       = time_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    x_nxt          = x_r;
    run_nxt        = run_r;
    c_nxt          = c_r;
    hasr_nxt       = hasr_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_time_nxt   = res_time_r;
    res_rem_nxt    = res_rem_r;
    res_resp_nxt   = res_resp_r;
    we             = 1'b0;
    wa             = pos_r;
    wd             = x_r;
    ra             = '0;
    fin_load       = 1'b0;
    out_load       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          id_nxt    = in_job_id;
          prio_nxt  = in_job_priority;
          burst_nxt = in_job_burst;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_time_nxt = time_r;
        res_id_nxt   = '0;
        res_rem_nxt  = '0;
        res_resp_nxt = '0;
        if (cmd_r == CMD_ARRIVE) begin
          if (burst_r == '0) begin
            res_status_nxt = ST_REJ_ZERO;
            state_nxt      = S_DONE;
          end else if (count_r >= CW'(HEAP_DEPTH)) begin
            res_status_nxt = ST_REJ_FULL;
            state_nxt      = S_DONE;
          end else begin
            x_nxt.id        = id_r;
            x_nxt.prio      = prio_r;
            x_nxt.remaining = burst_r;
            x_nxt.original  = burst_r;
            x_nxt.arrival   = time_r;
            x_nxt.resp      = '0;
            x_nxt.started   = 1'b0;
            res_status_nxt  = ST_ACCEPT;
            res_id_nxt      = id_r;
            res_rem_nxt     = burst_r;
            pos_nxt         = AW'(count_r);
            count_nxt       = count_r + CW'(1);
            state_nxt       = S_UP;
          end
        end else begin
          if (time_r != {TIME_W{1'b1}}) begin
            time_nxt = time_r + TIME_W'(1);
          end
          if (count_r == '0) begin
            res_status_nxt = ST_IDLE;
            state_nxt      = S_DONE;
          end else begin
            ra        = '0;
            state_nxt = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        run_nxt           = rd_r;
        run_nxt.resp      = root_resp;
        run_nxt.started   = 1'b1;
        run_nxt.remaining = root_rem;
        res_id_nxt        = rd_r.id;
        res_rem_nxt       = root_rem;
        res_resp_nxt      = root_resp;
        res_status_nxt    = (root_rem != '0) ? ST_RAN : ST_FINISHED;
        fin_load          = 1'b1;
        count_nxt         = count_r - CW'(1);
        if (count_r > CW'(1)) begin
          ra        = AW'(count_r - CW'(1));
          state_nxt = S_LAST;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_LAST: begin
        x_nxt     = rd_r;
        pos_nxt   = '0;
        state_nxt = S_DN_L;
      end
      S_DN_L: begin
        if (l_x < cnt_x) begin
          ra        = l_x[AW-1:0];
          state_nxt = S_DN_R;
        end else begin
          we        = 1'b1;
          state_nxt = S_PUSH;
        end
      end
      S_DN_R: begin
        c_nxt = rd_r;
        if (r_x < cnt_x) begin
          ra       = r_x[AW-1:0];
          hasr_nxt = 1'b1;
        end else begin
          hasr_nxt = 1'b0;
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (pick_r) begin
          wd        = rd_r;
          pos_nxt   = r_x[AW-1:0];
          state_nxt = S_DN_L;
        end else if (pick_l) begin
          wd        = c_r;
          pos_nxt   = l_x[AW-1:0];
          state_nxt = S_DN_L;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (run_r.remaining != '0) begin
          x_nxt     = run_r;
          pos_nxt   = AW'(count_r);
          count_nxt = count_r + CW'(1);
          state_nxt = S_UP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_UP: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ra        = par;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (rd_r.prio > x_r.prio) begin
          wd        = rd_r;
          pos_nxt   = par;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (((res_status_r != ST_FINISHED) || fin_done) && (!out_valid_r || out_ready)) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      time_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    prio_r       <= prio_nxt;
    burst_r      <= burst_nxt;
    pos_r        <= pos_nxt;
    x_r          <= x_nxt;
    run_r        <= run_nxt;
    c_r          <= c_nxt;
    hasr_r       <= hasr_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_time_r   <= res_time_nxt;
    res_rem_r    <= res_rem_nxt;
    res_resp_r   <= res_resp_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_time_r   <= res_time_r;
      out_rem_r    <= res_rem_r;
      out_resp_r   <= res_resp_r;
      out_wait_r   <= (res_status_r == ST_FINISHED) ? fin_stats.waiting : '0;
      out_turn_r   <= (res_status_r == ST_FINISHED) ? fin_stats.turnaround : '0;
    end
  end

  pps_finish u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fin_load),
    .now      (res_time_r),
    .arrival  (rd_r.arrival),
    .original (rd_r.original),
    .stats    (fin_stats),
    .done     (fin_done)
  );

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_run_id          = out_id_r;
  assign out_tick_time       = out_time_r;
  assign out_remaining_burst = out_rem_r;
  assign out_response_time   = out_resp_r;
  assign out_waiting_time    = out_wait_r;
  assign out_turnaround_time = out_turn_r;

endmodule

`default_nettype wire

/* src/pps_checker.sv */
`default_nettype none

module pps_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [pps_pkg::CMD_W-1:0]    in_cmd,
  input logic [pps_pkg::ID_W-1:0]     in_job_id,
  input logic [pps_pkg::PRIO_W-1:0]   in_job_priority,
  input logic [pps_pkg::BURST_W-1:0]  in_job_burst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pps_pkg::STATUS_W-1:0] out_status,
  input logic [pps_pkg::ID_W-1:0]     out_run_id,
  input logic [pps_pkg::TIME_W-1:0]   out_tick_time,
  input logic [pps_pkg::BURST_W-1:0]  out_remaining_burst,
  input logic [pps_pkg::TIME_W-1:0]   out_response_time,
  input logic [pps_pkg::TIME_W-1:0]   out_waiting_time,
  input logic [pps_pkg::TIME_W-1:0]   out_turnaround_time
);
  import pps_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_status) && $stable(out_tick_time))
    else $error("result changed while stalled");

  a_no_job_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_REJ_FULL || out_status == ST_REJ_ZERO ||
                  out_status == ST_IDLE) |->
      out_run_id == '0 && out_remaining_burst == '0 && out_response_time == '0 &&
      out_waiting_time == '0 && out_turnaround_time == '0)
    else $error("reject or idle result carries job fields");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FINISHED |->
      out_remaining_burst == '0 && out_turnaround_time >= out_waiting_time &&
      out_turnaround_time != '0)
    else $error("finished result inconsistent");

  a_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_RAN || out_status == ST_ACCEPT) |->
      out_remaining_burst != '0 && out_waiting_time == '0 &&
      out_turnaround_time == '0)
    else $error("running or accepted job has bad burst or finish times");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

`default_nettype wire

/* tb/tb_preemptive_priority_scheduler.sv */
`default_nettype none

module tb_preemptive_priority_scheduler;
  import pps_pkg::*;

  localparam int DEPTH        = HEAP_DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 64;
  localparam int NUM_ITEMS    = 750;
  localparam int HOLD_AFTER   = 250;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } job_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     run_id;
    logic [TIME_W-1:0]   tick_time;
    logic [BURST_W-1:0]  remaining;
    logic [TIME_W-1:0]   response;
    logic [TIME_W-1:0]   waiting;
    logic [TIME_W-1:0]   turnaround;
  } sched_out_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_cmd = CMD_TICK;
  logic [ID_W-1:0]     in_job_id = '0;
  logic [PRIO_W-1:0]   in_job_priority = '0;
  logic [BURST_W-1:0]  in_job_burst = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_run_id;
  logic [TIME_W-1:0]   out_tick_time;
  logic [BURST_W-1:0]  out_remaining_burst;
  logic [TIME_W-1:0]   out_response_time;
  logic [TIME_W-1:0]   out_waiting_time;
  logic [TIME_W-1:0]   out_turnaround_time;

  preemptive_priority_scheduler dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_job_id           (in_job_id),
    .in_job_priority     (in_job_priority),
    .in_job_burst        (in_job_burst),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_run_id          (out_run_id),
    .out_tick_time       (out_tick_time),
    .out_remaining_burst (out_remaining_burst),
    .out_response_time   (out_response_time),
    .out_waiting_time    (out_waiting_time),
    .out_turnaround_time (out_turnaround_time)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Scheduler shadow state
  heap_entry_t       ready_heap [DEPTH];
  int                ready_count = 0;
  logic [TIME_W-1:0] sched_now = '0;

  job_req_t   job_req_q [$];
  sched_out_t outcome_q [$];
  job_req_t   cur_req;
  int         err_cnt = 0;
  int         accepted_cnt = 0;
  int         cycle_cnt = 0;
  int         burst_left = 1;
  int         gap_left = 0;

  function automatic void heap_swap(int a, int b);
    heap_entry_t t;
    t = ready_heap[a];
    ready_heap[a] = ready_heap[b];
    ready_heap[b] = t;
  endfunction

  function automatic void heap_insert(heap_entry_t e);
    int pos;
    int parent;
    pos = ready_count;
    ready_heap[pos] = e;
    ready_count++;
    while (pos != 0) begin
      parent = (pos - 1) / 2;
      if (ready_heap[parent].prio <= ready_heap[pos].prio) break;
      heap_swap(parent, pos);
      pos = parent;
    end
  endfunction

  function automatic void heap_sift_down();
    int pos;
    int best;
    int l;
    int r;
    bit done;
    pos = 0;
    done = 1'b0;
    while (!done) begin
      best = pos;
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      if (l < ready_count && ready_heap[l].prio < ready_heap[best].prio) best = l;
      if (r < ready_count && ready_heap[r].prio < ready_heap[best].prio) best = r;
      if (best == pos) begin
        done = 1'b1;
      end else begin
        heap_swap(best, pos);
        pos = best;
      end
    end
  endfunction

  function automatic sched_out_t schedule_step(job_req_t rq);
    sched_out_t        o;
    heap_entry_t       e;
    logic [BURST_W-1:0] rem;
    logic [63:0]       plus;
    logic [63:0]       minus;
    logic [63:0]       wt;
    logic [63:0]       tn;
    o = '0;
    o.tick_time = sched_now;
    if (rq.cmd == CMD_ARRIVE) begin
      if (rq.burst == '0) begin
        o.status = ST_REJ_ZERO;
      end else if (ready_count >= DEPTH) begin
        o.status = ST_REJ_FULL;
      end else begin
        e = '0;
        e.id = rq.id;
        e.prio = rq.prio;
        e.remaining = rq.burst;
        e.original = rq.burst;
        e.arrival = sched_now;
        heap_insert(e);
        o.status = ST_ACCEPT;
        o.run_id = rq.id;
        o.remaining = rq.burst;
      end
      return o;
    end
    if (ready_count == 0) begin
      o.status = ST_IDLE;
    end else begin
      e = ready_heap[0];
      if (!e.started) e.resp = sched_now - e.arrival;
      ready_count--;
      if (ready_count >= 1) begin
        ready_heap[0] = ready_heap[ready_count];
        heap_sift_down();
      end
      rem = e.remaining;
      if (rem != '0) rem--;
      o.run_id = e.id;
      o.remaining = rem;
      o.response = e.resp;
      if (rem != '0) begin
        e.remaining = rem;
        e.started = 1'b1;
        heap_insert(e);
        o.status = ST_RAN;
      end else begin
        plus = {32'd0, sched_now} + 64'd1;
        minus = {32'd0, e.arrival} + {48'd0, e.original};
        wt = (plus > minus) ? plus - minus : 64'd0;
        if (wt > 64'hFFFF_FFFF) wt = 64'hFFFF_FFFF;
        tn = wt + {48'd0, e.original};
        if (tn > 64'hFFFF_FFFF) tn = 64'hFFFF_FFFF;
        o.status = ST_FINISHED;
        o.waiting = wt[31:0];
        o.turnaround = tn[31:0];
      end
    end
    if (sched_now != '1) sched_now++;
    return o;
  endfunction

  task automatic add_arrival(logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                             logic [BURST_W-1:0] burst);
    job_req_q.push_back('{CMD_ARRIVE, id, prio, burst});
  endtask

  task automatic add_tick();
    job_req_q.push_back('{CMD_TICK, ID_W'($urandom_range(0, 255)),
                         PRIO_W'($urandom_range(0, 255)),
                         BURST_W'($urandom_range(0, 65535))});
  endtask

  task automatic add_random_arrival(int max_burst);
    int r;
    logic [BURST_W-1:0] b;
    logic [PRIO_W-1:0]  p;
    r = $urandom_range(0, 99);
    if (r < 3) b = '0;
    else if (r < 7) b = BURST_W'($urandom_range(0, 65535));
    else if (r < 75) b = BURST_W'($urandom_range(1, 2));
    else b = BURST_W'($urandom_range(1, max_burst));
    if ($urandom_range(0, 1) == 0) p = PRIO_W'($urandom_range(0, 3));
    else p = PRIO_W'($urandom_range(0, 255));
    add_arrival(ID_W'($urandom_range(0, 255)), p, b);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(5, 40);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        outcome_q.push_back(schedule_step(cur_req));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (job_req_q.size() != 0) begin
          cur_req = job_req_q.pop_front();
          in_cmd <= cur_req.cmd;
          in_job_id <= cur_req.id;
          in_job_priority <= cur_req.prio;
          in_job_burst <= cur_req.burst;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = pick_gap();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_pct = 0;
  int phase_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (phase_left <= 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 90;
        endcase
        phase_left = $urandom_range(16, 96);
      end
      phase_left--;
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    sched_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t mismatch unexpected result: expected none, actual status %0d",
                 $time, out_status);
        err_cnt++;
      end else begin
        want = outcome_q.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("run_id", 32'(want.run_id), 32'(out_run_id));
        check_field("tick_time", want.tick_time, out_tick_time);
        check_field("remaining_burst", 32'(want.remaining), 32'(out_remaining_burst));
        check_field("response_time", want.response, out_response_time);
        check_field("waiting_time", want.waiting, out_waiting_time);
        check_field("turnaround_time", want.turnaround, out_turnaround_time);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL preemptive_priority_scheduler");
      $finish;
    end
  end

  initial begin
    int seg_len;
    int pct;
    // directed: idle, zero burst, field extremes, ties, preemption
    add_tick();
    add_arrival(8'hFF, 8'h00, 16'd0);
    add_arrival(8'h00, 8'hFF, 16'hFFFF);
    add_arrival(8'hFF, 8'h00, 16'd1);
    add_tick();
    add_arrival(8'd1, 8'd5, 16'd2);
    add_arrival(8'd2, 8'd5, 16'd2);
    add_arrival(8'd3, 8'd3, 16'd1);
    repeat (5) add_tick();
    add_arrival(8'd4, 8'd10, 16'd3);
    add_tick();
    add_arrival(8'd5, 8'd1, 16'd1);
    repeat (3) add_tick();
    // fill past capacity
    repeat (DEPTH + 6) add_arrival(ID_W'($urandom_range(0, 255)),
                                   PRIO_W'($urandom_range(0, 255)),
                                   BURST_W'($urandom_range(1, 3)));
    while (job_req_q.size() < NUM_ITEMS) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 3))
        0: pct = 15;
        1: pct = 30;
        2: pct = 30;
        default: pct = 60;
      endcase
      repeat (seg_len) begin
        if ($urandom_range(0, 99) < pct) add_random_arrival(12);
        else add_tick();
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (job_req_q.size() != 0 || in_valid || outcome_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS preemptive_priority_scheduler");
    end else begin
      $display("FAIL preemptive_priority_scheduler");
    end
    $finish;
  end

endmodule

`default_nettype wire
